>>> src/diel_pkg.sv
package diel_pkg;

    localparam int DEPTH      = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int TICK_W     = 32;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // tdata layouts, padded to whole bytes
    localparam int IN_DATA_W  = ((TICK_W + 1 + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + TICK_W + 32 + CNT_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [31:0] DEBOUNCE_RST  = 32'd100;
    localparam logic [31:0] TICK_RATE_RST = 32'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = CFG_IDX_W'(1);

    localparam logic OP_POLL      = 1'b0;
    localparam logic OP_REPORT    = 1'b1;
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_EVENT   = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [TICK_W-1:0] tick_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    typedef struct packed {
        logic accept_poll;
        logic accept_report;
        logic load_event;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;    // output register empty or being taken
        logic ring_empty;
        logic last_event;   // entry at read pointer is the newest one
    } dp_status_t;

    typedef struct packed {
        logic  level;
        tick_t tick;
    } event_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    function automatic ptr_t ring_count(input ptr_t wr, input ptr_t rd);
        logic [PTR_W:0] diff;
        if (wr >= rd)
        begin
            diff = {1'b0, wr} - {1'b0, rd};
        end
        else
        begin
            diff = {1'b0, wr} + (PTR_W+1)'(DEPTH) - {1'b0, rd};
        end
        return diff[PTR_W-1:0];
    endfunction

endpackage

>>> src/diel_ctrl.sv
module diel_ctrl
    import diel_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_opcode,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE) && status.slot_free;
        accept         = in_valid && in_ready;
        cmd.accept_poll   = accept && (in_opcode == OP_POLL);
        cmd.accept_report = accept && (in_opcode == OP_REPORT);
        cmd.load_event    = (state_reg == ST_DRAIN) && status.slot_free;
        state_next     = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept_report && !status.ring_empty)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.load_event && status.last_event)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_report_enters_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_report && !status.ring_empty) |=> (state_reg == ST_DRAIN))
        else $error("report with stored events did not start draining");

    a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> !(cmd.accept_poll || cmd.accept_report))
        else $error("item accepted while draining");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
`endif

endmodule

>>> src/diel_datapath.sv
module diel_datapath
    import diel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  tick_t                 in_tick,
    input  logic                  in_pin,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_kind,
    output logic                  out_last
);

    logic [31:0] debounce_reg;
    logic [31:0] tick_rate_reg;

    logic  level_reg;
    tick_t last_sample_reg;
    ptr_t  rd_ptr_reg;
    ptr_t  rd_ptr_next;
    ptr_t  wr_ptr_reg;
    logic  overflow_reg;

    event_t ring_mem [DEPTH];
    event_t rdata_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic        out_level_reg;
    tick_t       out_tick_reg;
    logic [31:0] out_rate_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic        out_ovf_reg;
    logic        out_last_reg;

    tick_t elapsed;
    logic  do_sample;
    logic  level_change;
    logic  ring_full;
    ptr_t  wr_inc;
    ptr_t  rd_inc;
    ptr_t  count;

    always_comb
    begin
        elapsed      = in_tick - last_sample_reg;
        do_sample    = elapsed >= debounce_reg;
        level_change = do_sample && (in_pin != level_reg);
        wr_inc       = next_ptr(wr_ptr_reg);
        rd_inc       = next_ptr(rd_ptr_reg);
        ring_full    = (wr_inc == rd_ptr_reg);
        count        = ring_count(wr_ptr_reg, rd_ptr_reg);
        rd_ptr_next  = cmd.load_event ? rd_inc : rd_ptr_reg;

        status.slot_free  = !out_valid_reg || out_ready;
        status.ring_empty = (wr_ptr_reg == rd_ptr_reg);
        status.last_event = (rd_inc == wr_ptr_reg);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RST;
            tick_rate_reg <= TICK_RATE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                CFG_TICK_RATE: tick_rate_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // debounce state and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 1'b0;
            last_sample_reg <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            overflow_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            if (cmd.accept_poll && do_sample)
            begin
                last_sample_reg <= in_tick;
            end
            if (cmd.accept_poll && level_change)
            begin
                level_reg <= in_pin;
                if (ring_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    wr_ptr_reg <= wr_inc;
                end
            end
        end
    end

    // event store; read data always tracks the next read pointer
    always_ff @(posedge clk)
    begin
        if (cmd.accept_poll && level_change && !ring_full)
        begin
            ring_mem[wr_ptr_reg] <= '{level: in_pin, tick: in_tick};
        end
        rdata_reg <= ring_mem[rd_ptr_next];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.accept_report || cmd.load_event)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_report)
        begin
            out_kind_reg  <= KIND_HEADER;
            out_level_reg <= level_reg;
            out_tick_reg  <= in_tick;
            out_rate_reg  <= tick_rate_reg;
            out_count_reg <= CNT_W'(count);
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= status.ring_empty;
        end
        else if (cmd.load_event)
        begin
            out_kind_reg  <= KIND_EVENT;
            out_level_reg <= rdata_reg.level;
            out_tick_reg  <= rdata_reg.tick;
            out_rate_reg  <= '0;
            out_count_reg <= '0;
            out_ovf_reg   <= overflow_reg;
            out_last_reg  <= status.last_event;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {(OUT_DATA_W - OUT_BITS)'(0), out_ovf_reg, out_count_reg,
                        out_rate_reg, out_tick_reg, out_level_reg};

`ifndef SYNTHESIS
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_event |-> !status.ring_empty)
        else $error("event popped from empty ring");

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(overflow_reg))
        else $error("overflow flag cleared");

    a_full_sets_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_poll && level_change && ring_full) |=> overflow_reg)
        else $error("dropped event did not set overflow");
`endif

endmodule

>>> src/debounced_input_event_logger_top.sv
// Debounced input event logger.
// Input stream s_axis_*: one transfer is either a poll (tuser = 0) carrying the
// current tick and the raw pin level, or a report request (tuser = 1).
// A poll samples the pin once the debounce interval has passed since the last
// sample (tick difference taken modulo 2^32); a level change is stored with
// its tick in a 16-entry ring (15 usable). A change while full is dropped and
// the sticky overflow bit is set.
// A report gives a header record and then every stored event, oldest first,
// on m_axis_*; tlast marks the final record of the report.
// Timing: a poll gives no record; polls may arrive every cycle while the block
// is idle and the output register is free. A report's header is registered and
// shows up in the cycle after acceptance, followed by one event per cycle while
// the receiver takes them. No new item is taken until the last record of a
// report has been loaded into the output register.
// A receiver stall holds the output register and pauses the drain; a poll or
// report is taken only when the output register is free or being emptied.
// Config writes (cfg_*) are always accepted; index 0 = debounce interval,
// index 1 = ticks per second, other indexes ignored.
// Reset clears the debounce state, pointers and overflow flag, and loads the
// interval with 100 and the tick rate with 1000.
module debounced_input_event_logger_top
    import diel_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // now_tick[31:0], pin_level[32]
    input  logic                  s_axis_tuser,   // opcode

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // level[0], tick_value[32:1],
                                                  // rate_value[64:33],
                                                  // event_count[68:65],
                                                  // overflow[69]
    output logic                  m_axis_tuser,   // record_kind
    output logic                  m_axis_tlast    // last_record
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // config is a plain register write, never stalls
    assign cfg_ready = 1'b1;

    diel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    diel_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_tick   (s_axis_tdata[TICK_W-1:0]),
        .in_pin    (s_axis_tdata[TICK_W]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> sim/debounced_input_event_logger_top_tb.sv
`timescale 1ns / 100ps

module debounced_input_event_logger_top_tb;

    import diel_pkg::*;

    localparam int SETTLE_CYCLES   = 4;     // a poll's state is registered when it is taken
    localparam int END_DRAIN       = 20;
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on any channel
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int STEADY_PHASE    = 3;     // no idling on either side in this phase
    localparam int MAX_SHOWN       = 10;

    // unused register slots, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    typedef struct packed {
        logic            kind;
        logic            level;
        tick_t           tick;
        logic [31:0]     rate;
        logic [CNT_W-1:0] count;
        logic            ovf;
        logic            last;
    } record_t;

    // one directed stimulus row; hdr is used only when typed is set
    typedef struct packed {
        logic    op;
        tick_t   tick;
        logic    pin;
        logic    typed;
        record_t hdr;
    } row_t;

    localparam record_t NO_HDR = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // predictor state
    logic        level_q;
    tick_t       last_tick_q;
    ptr_t        rd_q;
    ptr_t        wr_q;
    tick_t       ring_tick [DEPTH];
    logic        ring_level [DEPTH];
    logic        ovf_q;
    logic [31:0] debounce_q;
    logic [31:0] rate_q;

    record_t pending_records [$];
    row_t    directed_rows [$];
    int      errors = 0;
    int      stall_cycles = 0;
    bit      steady = 1'b0;

    debounced_input_event_logger_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string fmt_record(input record_t r);
        return $sformatf("kind=%0d level=%0d tick=%08h rate=%08h count=%0d ovf=%0d last=%0d",
                         r.kind, r.level, r.tick, r.rate, r.count, r.ovf, r.last);
    endfunction

    // Applies one accepted transfer to the predicted logger state; a report
    // queues its header and every stored event when emit is set.
    function automatic void log_and_report(input logic op, input tick_t now, input logic pin,
                                           input bit emit);
        tick_t   elapsed;
        ptr_t    nxt;
        int      cnt;
        record_t r;
        if (op == OP_POLL)
        begin
            elapsed = now - last_tick_q;
            if (elapsed >= debounce_q)
            begin
                last_tick_q = now;
                if (pin != level_q)
                begin
                    level_q = pin;
                    nxt = ptr_t'((int'(wr_q) + 1) % DEPTH);
                    if (nxt == rd_q)
                    begin
                        ovf_q = 1'b1;   // ring full, change dropped
                    end
                    else
                    begin
                        ring_tick[wr_q]  = now;
                        ring_level[wr_q] = pin;
                        wr_q = nxt;
                    end
                end
            end
        end
        else
        begin
            cnt = (int'(wr_q) + DEPTH - int'(rd_q)) % DEPTH;
            r = '{kind: KIND_HEADER, level: level_q, tick: now, rate: rate_q,
                  count: CNT_W'(cnt), ovf: ovf_q, last: (cnt == 0)};
            if (emit)
            begin
                pending_records.push_back(r);
            end
            for (int i = 0; i < cnt; i++)
            begin
                r = '{kind: KIND_EVENT, level: ring_level[rd_q], tick: ring_tick[rd_q],
                      rate: '0, count: '0, ovf: ovf_q, last: (i + 1 == cnt)};
                if (emit)
                begin
                    pending_records.push_back(r);
                end
                rd_q = ptr_t'((int'(rd_q) + 1) % DEPTH);
            end
        end
    endfunction

    // Sender side: random gap outside the steady phase, then hold the transfer until it is taken.
    task automatic send_item(input logic op, input tick_t now, input logic pin);
        if (!steady && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (!steady && $urandom_range(0, 99) < 33);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - TICK_W - 1){1'b0}}, pin, now};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_DEBOUNCE)
        begin
            debounce_q = value;
        end
        else if (idx == CFG_TICK_RATE)
        begin
            rate_q = value;
        end
    endtask

    // Registers change only with the block idle: all records out, last poll settled.
    task automatic configure(input logic [31:0] deb, input logic [31:0] rate);
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_TICK_RATE, rate);
        cfg_valid <= 1'b0;
    endtask

    // Tick near the debounce boundary most of the time, else shortly after the last sample or anywhere.
    function automatic tick_t pick_tick();
        tick_t t;
        case ($urandom_range(0, 4))
            0:       t = last_tick_q + debounce_q;
            1:       t = last_tick_q + debounce_q - 1;
            2:       t = last_tick_q + debounce_q + $urandom_range(1, 300);
            3:       t = $urandom();
            default: t = last_tick_q + $urandom_range(0, 300);
        endcase
        return t;
    endfunction

    // Receiver side: random stalls except in the steady phase.
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    // Record checker: every output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        record_t got;
        record_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[64:33],
                   m_axis_tdata[68:65], m_axis_tdata[69], m_axis_tlast};
            if (pending_records.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                begin
                    $display("unexpected record: %s", fmt_record(got));
                end
            end
            else
            begin
                want = pending_records.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                    begin
                        $display("record mismatch at %0t", $realtime);
                        $display("  want: %s", fmt_record(want));
                        $display("  got:  %s", fmt_record(got));
                    end
                end
            end
        end
    end

    // Watchdog: too long with no transfer on any channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        logic  op;
        logic  pin;
        tick_t now;

        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_POLL;

        level_q     = 1'b0;
        last_tick_q = '0;
        rd_q        = '0;
        wr_q        = '0;
        ovf_q       = 1'b0;
        debounce_q  = DEBOUNCE_RST;
        rate_q      = TICK_RATE_RST;

        // Directed table. Empty reports right after reset carry a typed header.
        directed_rows.push_back({OP_REPORT, 32'h0000_0000, 1'b0, 1'b1,
            record_t'({KIND_HEADER, 1'b0, 32'h0000_0000, 32'd1000, 4'd0, 1'b0, 1'b1})});
        directed_rows.push_back({OP_REPORT, 32'hFFFF_FFFF, 1'b1, 1'b1,
            record_t'({KIND_HEADER, 1'b0, 32'hFFFF_FFFF, 32'd1000, 4'd0, 1'b0, 1'b1})});
        directed_rows.push_back({OP_POLL, 32'd50,  1'b1, 1'b0, NO_HDR});  // too early
        directed_rows.push_back({OP_POLL, 32'd100, 1'b1, 1'b0, NO_HDR});  // exact interval
        directed_rows.push_back({OP_POLL, 32'd200, 1'b1, 1'b0, NO_HDR});  // sample, no change
        directed_rows.push_back({OP_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_HDR});
        directed_rows.push_back({OP_POLL, 32'h0000_0063, 1'b1, 1'b0, NO_HDR});  // across wrap
        directed_rows.push_back({OP_REPORT, 32'h0000_0064, 1'b0, 1'b0, NO_HDR});
        // sixteen changes into an empty ring: fifteen stored, the last one overflows
        for (int i = 0; i < 16; i++)
        begin
            directed_rows.push_back({OP_POLL, tick_t'((i + 1) * 256), logic'(i % 2 == 1),
                                     1'b0, NO_HDR});
        end
        directed_rows.push_back({OP_REPORT, 32'h0000_2000, 1'b0, 1'b0, NO_HDR});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // spare register slots must leave both settings untouched
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        cfg_valid <= 1'b0;

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].op, directed_rows[i].tick, directed_rows[i].pin);
            log_and_report(directed_rows[i].op, directed_rows[i].tick, directed_rows[i].pin,
                           !directed_rows[i].typed);
            if (directed_rows[i].typed)
            begin
                pending_records.push_back(directed_rows[i].hdr);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       configure(32'd1, 32'd1);
                1:       configure(32'd0, 32'hFFFF_FFFF);   // every poll samples
                2:       configure(32'hFFFF_FFFF, 32'h8000_0001);
                3:       configure($urandom_range(1, 500), $urandom());
                default: configure(DEBOUNCE_RST, TICK_RATE_RST);
            endcase
            steady = (ph == STEADY_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                op  = ($urandom_range(0, 5) == 0) ? OP_REPORT : OP_POLL;
                now = pick_tick();
                // mostly toggles so the ring fills between reports
                pin = ($urandom_range(0, 9) < 7) ? ~level_q : logic'($urandom_range(0, 1));
                send_item(op, now, pin);
                log_and_report(op, now, pin, 1'b1);
            end
            s_axis_tvalid <= 1'b0;
        end
        steady = 1'b0;

        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);

        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
src/diel_pkg.sv
src/diel_ctrl.sv
src/diel_datapath.sv
src/debounced_input_event_logger_top.sv
sim/debounced_input_event_logger_top_tb.sv
